FILE: sv/bbc_pkg.sv
`timescale 1ns / 1ps
package bbc_pkg;

   localparam int SLOTS_DEF       = 48;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int BLOCK_BITS_DEF  = 32;
   localparam int REF_BITS_DEF    = 8;

   localparam int BLK_OUT_W = 48;

   localparam logic [2:0] F_READ      = 3'd0;
   localparam logic [2:0] F_OVERWRITE = 3'd1;
   localparam logic [2:0] F_ACCESS    = 3'd2;
   localparam logic [2:0] F_RELEASE   = 3'd3;
   localparam logic [2:0] F_MARK      = 3'd4;
   localparam logic [2:0] F_FLUSH     = 3'd5;

   localparam logic [1:0] K_ANSWER = 2'd0;
   localparam logic [1:0] K_FETCH  = 2'd1;
   localparam logic [1:0] K_WBACK  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RES   = 3'd1;
   localparam logic [2:0] ST_NO_SLOT   = 3'd2;
   localparam logic [2:0] ST_BAD_HND   = 3'd3;
   localparam logic [2:0] ST_REF_OVF   = 3'd4;

   localparam logic [0:0] CSR_CACHE_ENTRIES = 1'd0;
   localparam logic [0:0] CSR_SIZE_SHIFT    = 1'd1;

   localparam logic [4:0] CACHE_ENTRIES_RST = 5'd16;
   localparam logic [4:0] SIZE_SHIFT_RST    = 5'd12;

   typedef struct packed {
      logic [1:0]           kind;
      logic [2:0]           status;
      logic [5:0]           slot;
      logic [BLK_OUT_W-1:0] blk;
      logic                 hit;
      logic                 last;
   } emit_type;

endpackage

FILE: sv/bbc_ram.sv
`timescale 1ns / 1ps
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: sv/bbc_out.sv
`timescale 1ns / 1ps
module bbc_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               emit_go,
   input  bbc_pkg::emit_type  emit,
   input  logic [4:0]         size_shift,
   output logic               out_free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata,  // status, slot, block_id, byte_offset, hit, pad
   output logic [1:0]         rsp_tuser,  // kind
   output logic               rsp_tlast
);
   import bbc_pkg::*;

   logic        valid_ff, valid_in;
   logic [95:0] data_ff, data_in;
   logic [1:0]  user_ff, user_in;
   logic        last_ff, last_in;
   logic [47:0] offset;

   assign out_free = !valid_ff || rsp_tready;
   assign offset   = 48'(emit.blk << size_shift);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (emit_go) begin
         valid_in = 1'b1;
         data_in  = {6'd0, emit.hit, offset, emit.blk[31:0], emit.slot, emit.status};
         user_in  = emit.kind;
         last_in  = emit.last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;
endmodule

FILE: sv/bbc_ctrl.sv
`timescale 1ns / 1ps
module bbc_ctrl #(
   parameter int SLOTS       = bbc_pkg::SLOTS_DEF,
   parameter int QUEUE_DEPTH = bbc_pkg::QUEUE_DEPTH_DEF,
   parameter int BLOCK_BITS  = bbc_pkg::BLOCK_BITS_DEF,
   parameter int REF_BITS    = bbc_pkg::REF_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_go,
   input  logic [2:0]                        func,
   input  logic [BLOCK_BITS-1:0]             blk,
   input  logic [5:0]                        hnd,
   output logic                              idle,
   input  logic [4:0]                        cache_entries,
   input  logic                              out_free,
   output logic                              emit_go,
   output bbc_pkg::emit_type                 emit,
   output logic                              ram_we,
   output logic [$clog2(SLOTS)-1:0]          ram_waddr,
   output logic [REF_BITS+BLOCK_BITS:0]      ram_wdata,
   output logic [$clog2(SLOTS)-1:0]          ram_raddr,
   input  logic [REF_BITS+BLOCK_BITS:0]      ram_rdata
);
   import bbc_pkg::*;

   localparam int SW     = $clog2(SLOTS);
   localparam int SCW    = $clog2(SLOTS + 1);
   localparam int QW     = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W = 1 + REF_BITS + BLOCK_BITS;
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_LOOKUP = 4'd2;
   localparam logic [3:0] S_FETCH  = 4'd3;
   localparam logic [3:0] S_QCHK   = 4'd4;
   localparam logic [3:0] S_DR_RD  = 4'd5;
   localparam logic [3:0] S_DR_CHK = 4'd6;
   localparam logic [3:0] S_DR_WB  = 4'd7;
   localparam logic [3:0] S_UPD_RD = 4'd8;
   localparam logic [3:0] S_UPD    = 4'd9;
   localparam logic [3:0] S_HND    = 4'd10;
   localparam logic [3:0] S_HND_DO = 4'd11;
   localparam logic [3:0] S_FL_END = 4'd12;
   localparam logic [3:0] S_FL_WB  = 4'd13;
   localparam logic [3:0] S_FIN    = 4'd14;

   logic [3:0]            state_ff, state_in;
   logic [3:0]            ret_ff, ret_in;
   logic [2:0]            func_ff, func_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [5:0]            hnd_ff, hnd_in;
   logic [SCW-1:0]        scan_ff, scan_in;
   logic                  rd_live_ff, rd_live_in;
   logic [SW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  hit_found_ff, hit_found_in;
   logic [SW-1:0]         hit_idx_ff, hit_idx_in;
   logic [WORD_W-1:0]     hit_word_ff, hit_word_in;
   logic                  free_found_ff, free_found_in;
   logic [SW-1:0]         free_idx_ff, free_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [SW-1:0]         best_idx_ff, best_idx_in;
   logic [WORD_W-1:0]     best_word_ff, best_word_in;
   logic [SW-1:0]         dr_slot_ff, dr_slot_in;
   logic [BLOCK_BITS-1:0] dr_blk_ff, dr_blk_in;
   emit_type              fin_ff, fin_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [QW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [SW-1:0]         q_ff [QUEUE_DEPTH];

   logic                  q_we;
   logic [QW-1:0]         q_waddr;
   logic [SW-1:0]         q_wdata;

   logic                  rd_dirty;
   logic [REF_BITS-1:0]   rd_refs;
   logic [BLOCK_BITS-1:0] rd_blk;
   logic [5:0]            lim6;
   logic                  need_pop;
   logic [QW:0]           tail_sum;
   logic [QW-1:0]         tail;
   logic [QW-1:0]         head_next;
   logic                  issue;
   logic                  f_over;

   assign rd_dirty = ram_rdata[WORD_W-1];
   assign rd_refs  = ram_rdata[WORD_W-2 -: REF_BITS];
   assign rd_blk   = ram_rdata[BLOCK_BITS-1:0];

   assign lim6 = (6'(cache_entries) > 6'(QUEUE_DEPTH)) ? 6'(QUEUE_DEPTH) : 6'(cache_entries);
   assign need_pop  = (count_ff != '0) && (6'(count_ff) >= lim6);
   assign tail_sum  = (QW+1)'(head_ff) + (QW+1)'(count_ff);
   assign tail      = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                      QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
   assign head_next = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign issue     = scan_ff < SCW'(SLOTS);
   assign f_over    = func_ff == F_OVERWRITE;
   assign idle      = state_ff == S_IDLE;

   always_comb begin
      case (state_ff)
         S_SCAN:   ram_raddr = scan_ff[SW-1:0];
         S_DR_RD:  ram_raddr = dr_slot_ff;
         S_UPD_RD: ram_raddr = free_idx_ff;
         S_HND:    ram_raddr = hnd_ff[SW-1:0];
         default:  ram_raddr = '0;
      endcase
   end

   always_comb begin
      emit = fin_ff;
      case (state_ff)
         S_FETCH: begin
            emit = '{kind: K_FETCH, status: ST_OK, slot: 6'(free_idx_ff),
                     blk: BLK_OUT_W'(blk_ff), hit: 1'b0, last: 1'b0};
         end
         S_DR_WB: begin
            emit = '{kind: K_WBACK, status: ST_OK, slot: 6'(dr_slot_ff),
                     blk: BLK_OUT_W'(dr_blk_ff), hit: 1'b0, last: 1'b0};
         end
         S_FL_WB: begin
            emit = '{kind: K_WBACK, status: ST_OK, slot: 6'(best_idx_ff),
                     blk: BLK_OUT_W'(best_word_ff[BLOCK_BITS-1:0]), hit: 1'b0, last: 1'b0};
         end
         default: emit = fin_ff;
      endcase
   end

   assign emit_go = out_free && (state_ff == S_FETCH || state_ff == S_DR_WB ||
                                 state_ff == S_FL_WB || state_ff == S_FIN);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      func_in       = func_ff;
      blk_in        = blk_ff;
      hnd_in        = hnd_ff;
      scan_in       = scan_ff;
      rd_live_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_word_in   = hit_word_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_word_in  = best_word_ff;
      dr_slot_in    = dr_slot_ff;
      dr_blk_in     = dr_blk_ff;
      fin_in        = fin_ff;
      valid_in      = valid_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      q_we          = 1'b0;
      q_waddr       = tail;
      q_wdata       = free_idx_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_go) begin
               func_in       = func;
               blk_in        = blk;
               hnd_in        = hnd;
               scan_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               fin_in        = '0;
               fin_in.last   = 1'b1;
               if (func <= F_ACCESS || func == F_FLUSH) begin
                  state_in = S_SCAN;
               end else if (func == F_RELEASE || func == F_MARK) begin
                  state_in = S_HND;
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         // one slot read is issued per cycle, compared in the next cycle
         S_SCAN: begin
            rd_live_in = issue;
            rd_idx_in  = scan_ff[SW-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rd_live_ff) begin
               if (func_ff == F_FLUSH) begin
                  if (valid_ff[rd_idx_ff] && rd_dirty &&
                      (!best_found_ff || rd_blk < best_word_ff[BLOCK_BITS-1:0])) begin
                     best_found_in = 1'b1;
                     best_idx_in   = rd_idx_ff;
                     best_word_in  = ram_rdata;
                  end
               end else begin
                  if (valid_ff[rd_idx_ff] && rd_blk == blk_ff && !hit_found_ff) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = rd_idx_ff;
                     hit_word_in  = ram_rdata;
                  end
                  if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = rd_idx_ff;
                  end
               end
            end
            if (!issue) begin
               state_in = (func_ff == F_FLUSH) ? S_FL_END : S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            fin_in = '{kind: K_ANSWER, status: ST_OK, slot: 6'd0,
                       blk: BLK_OUT_W'(blk_ff), hit: 1'b0, last: 1'b1};
            state_in = S_FIN;
            if (hit_found_ff) begin
               fin_in.slot = 6'(hit_idx_ff);
               fin_in.hit  = 1'b1;
               if (hit_word_ff[WORD_W-2 -: REF_BITS] == REF_MAX) begin
                  fin_in.status = ST_REF_OVF;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = hit_idx_ff;
                  ram_wdata = {hit_word_ff[WORD_W-1] | f_over,
                               hit_word_ff[WORD_W-2 -: REF_BITS] + 1'b1,
                               hit_word_ff[BLOCK_BITS-1:0]};
               end
            end else if (func_ff == F_ACCESS) begin
               fin_in.status = ST_NOT_RES;
            end else if (!free_found_ff) begin
               fin_in.status = ST_NO_SLOT;
            end else begin
               ram_we                = 1'b1;
               ram_waddr             = free_idx_ff;
               ram_wdata             = {1'b0, REF_BITS'(1), blk_ff};
               valid_in[free_idx_ff] = 1'b1;
               state_in = (func_ff == F_READ) ? S_FETCH : S_QCHK;
            end
         end

         S_FETCH: begin
            if (out_free) begin
               state_in = S_QCHK;
            end
         end

         S_QCHK: begin
            if (need_pop) begin
               head_in    = head_next;
               count_in   = count_ff - 1'b1;
               dr_slot_in = q_ff[head_ff];
               ret_in     = S_QCHK;
               state_in   = S_DR_RD;
            end else begin
               state_in = S_UPD_RD;
            end
         end

         S_DR_RD: state_in = S_DR_CHK;

         S_DR_CHK: begin
            state_in = ret_ff;
            if (valid_ff[dr_slot_ff] && rd_refs != '0) begin
               ram_we    = 1'b1;
               ram_waddr = dr_slot_ff;
               if (rd_refs == REF_BITS'(1)) begin
                  ram_wdata            = {1'b0, {REF_BITS{1'b0}}, rd_blk};
                  valid_in[dr_slot_ff] = 1'b0;
                  if (rd_dirty) begin
                     dr_blk_in = rd_blk;
                     state_in  = S_DR_WB;
                  end
               end else begin
                  ram_wdata = {rd_dirty, rd_refs - 1'b1, rd_blk};
               end
            end
         end

         S_DR_WB: begin
            if (out_free) begin
               state_in = ret_ff;
            end
         end

         S_UPD_RD: state_in = S_UPD;

         // queue reference and dirty mark land after the pops
         S_UPD: begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_ff;
            ram_wdata = {rd_dirty | f_over, rd_refs + REF_BITS'(lim6 != '0), rd_blk};
            if (lim6 != '0) begin
               q_we     = 1'b1;
               count_in = count_ff + 1'b1;
            end
            fin_in = '{kind: K_ANSWER, status: ST_OK, slot: 6'(free_idx_ff),
                       blk: BLK_OUT_W'(blk_ff), hit: 1'b0, last: 1'b1};
            state_in = S_FIN;
         end

         S_HND: begin
            if ({1'b0, hnd_ff} >= 7'(SLOTS) || !valid_ff[hnd_ff[SW-1:0]]) begin
               fin_in.status = ST_BAD_HND;
               fin_in.slot   = hnd_ff;
               state_in      = S_FIN;
            end else begin
               state_in = S_HND_DO;
            end
         end

         S_HND_DO: begin
            fin_in = '{kind: K_ANSWER, status: ST_OK, slot: hnd_ff,
                       blk: BLK_OUT_W'(rd_blk), hit: 1'b0, last: 1'b1};
            if (func_ff == F_MARK) begin
               ram_we    = 1'b1;
               ram_waddr = hnd_ff[SW-1:0];
               ram_wdata = {1'b1, rd_refs, rd_blk};
               state_in  = S_FIN;
            end else begin
               dr_slot_in = hnd_ff[SW-1:0];
               ret_in     = S_FIN;
               state_in   = S_DR_RD;
            end
         end

         S_FL_END: begin
            state_in = best_found_ff ? S_FL_WB : S_FIN;
         end

         S_FL_WB: begin
            if (out_free) begin
               ram_we        = 1'b1;
               ram_waddr     = best_idx_ff;
               ram_wdata     = {1'b0, best_word_ff[WORD_W-2:0]};
               scan_in       = '0;
               best_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end

         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_live_ff <= 1'b0;
         valid_ff   <= '0;
         head_ff    <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= rd_live_in;
         valid_ff   <= valid_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
      end
      ret_ff        <= ret_in;
      func_ff       <= func_in;
      blk_ff        <= blk_in;
      hnd_ff        <= hnd_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_word_ff   <= hit_word_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_word_ff  <= best_word_in;
      dr_slot_ff    <= dr_slot_in;
      dr_blk_ff     <= dr_blk_in;
      fin_ff        <= fin_in;
      if (q_we) begin
         q_ff[q_waddr] <= q_wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit_go && emit.last) |=> state_ff == S_IDLE)
      else $error("final beat did not return to idle");

   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP && !hit_found_ff && free_found_ff && func_ff != F_ACCESS)
         |-> !valid_ff[free_idx_ff])
      else $error("allocating a resident slot");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      q_we |=> count_ff != '0)
      else $error("queue empty after push");
endmodule

FILE: sv/block_buffer_cache_controller_top.sv
`timescale 1ns / 1ps
// lookup: from accept to the final beat in the output register, a scan of all SLOTS slots on
//   the shared comparator, a decision and an answer; a miss adds the queue update, the fetch
//   beat of a read, a reference drop per queue entry popped and a write-back beat per dirty slot freed
// release and mark dirty: handle check, slot read, answer; release drops a ref and may write back
// flush: one full scan per dirty block plus a last one; every beat waits for room
// one request at a time; synchronous active-high reset clears valid bits, queue pointers, loads config defaults
module block_buffer_cache_controller_top #(
   parameter int SLOTS       = bbc_pkg::SLOTS_DEF,
   parameter int QUEUE_DEPTH = bbc_pkg::QUEUE_DEPTH_DEF,
   parameter int BLOCK_BITS  = bbc_pkg::BLOCK_BITS_DEF,
   parameter int REF_BITS    = bbc_pkg::REF_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // block_number, handle_slot, pad
   input  logic [2:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // status, slot, block_id, byte_offset, hit, pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [4:0]  csr_wdata
);
   import bbc_pkg::*;

   localparam int SW     = $clog2(SLOTS);
   localparam int WORD_W = 1 + REF_BITS + BLOCK_BITS;

   logic [4:0]             ce_ff, ce_in;
   logic [4:0]             bsl_ff, bsl_in;
   logic                   req_go;
   logic                   idle;
   logic [BLK_OUT_W-1:0]   blk_ext;
   logic                   out_free;
   logic                   emit_go;
   emit_type               emit;
   logic                   ram_we;
   logic [SW-1:0]          ram_waddr;
   logic [WORD_W-1:0]      ram_wdata;
   logic [SW-1:0]          ram_raddr;
   logic [WORD_W-1:0]      ram_rdata;

   always_comb begin
      ce_in  = ce_ff;
      bsl_in = bsl_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CACHE_ENTRIES: ce_in  = csr_wdata;
            CSR_SIZE_SHIFT:    bsl_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ce_ff  <= CACHE_ENTRIES_RST;
         bsl_ff <= SIZE_SHIFT_RST;
      end else begin
         ce_ff  <= ce_in;
         bsl_ff <= bsl_in;
      end
   end

   assign req_tready = idle;
   assign req_go     = req_tvalid && req_tready;
   assign blk_ext    = BLK_OUT_W'(req_tdata[31:0]);

   bbc_ctrl #(
      .SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH),
      .BLOCK_BITS(BLOCK_BITS), .REF_BITS(REF_BITS)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .req_go(req_go), .func(req_tuser), .blk(blk_ext[BLOCK_BITS-1:0]),
      .hnd(req_tdata[37:32]), .idle(idle), .cache_entries(ce_ff),
      .out_free(out_free), .emit_go(emit_go), .emit(emit),
      .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
   );

   bbc_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   bbc_out u_out (
      .clock(clock), .reset(reset), .emit_go(emit_go), .emit(emit),
      .size_shift(bsl_ff), .out_free(out_free),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import bbc_pkg::*;

   localparam int NSLOT = 48;
   localparam int QDEPTH = 16;
   localparam int REF_TOP = 255;
   localparam longint CYCLE_LIMIT = 20000000;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [31:0] block_id;
      logic [47:0] offset;
      logic        hit;
      logic        last;
   } beat_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [0:0]  csr_addr;
   logic [4:0]  csr_wdata;

   // cache image kept by the predictor
   logic        img_valid [NSLOT];
   logic [31:0] img_block [NSLOT];
   int          img_refs  [NSLOT];
   logic        img_dirty [NSLOT];
   int          fifo_slot [QDEPTH];
   int          fifo_head;
   int          fifo_count;
   logic [4:0]  entries_reg;
   logic [4:0]  size_log_reg;

   beat_t       pending_beats[$];
   logic [31:0] blk_pool [24];
   int          send_idle_pct;
   int          stall_pct;
   int          hold_req;
   int          hold_done = 0;
   int          hold_left = 0;
   int          errors;
   longint      cycles = 0;

   block_buffer_cache_controller_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[block_buffer_cache_controller_top] ERROR");
         $finish;
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_req != hold_done) begin
            hold_left = hold_req;
            hold_done = hold_req;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic void push_beat(logic [1:0] k, logic [2:0] st, int s, logic [31:0] b,
                                     logic h, logic l);
      beat_t e;
      logic [79:0] wide;
      wide = {48'd0, b} << size_log_reg;
      e.kind = k; e.status = st; e.slot = s[5:0]; e.block_id = b;
      e.offset = wide[47:0]; e.hit = h; e.last = l;
      pending_beats.insert(pending_beats.size(), e);
   endfunction

   function automatic void write_back(int s);
      push_beat(K_WBACK, ST_OK, s, img_block[s], 1'b0, 1'b0);
      img_dirty[s] = 1'b0;
   endfunction

   function automatic void drop_ref(int s);
      if (!img_valid[s] || img_refs[s] == 0) return;
      img_refs[s]--;
      if (img_refs[s] == 0) begin
         if (img_dirty[s]) write_back(s);
         img_valid[s] = 1'b0;
      end
   endfunction

   function automatic void fifo_insert(int s);
      int lim;
      int old;
      lim = (entries_reg > QDEPTH) ? QDEPTH : entries_reg;
      while (fifo_count > 0 && fifo_count >= lim) begin
         old = fifo_slot[fifo_head];
         fifo_head = (fifo_head + 1) % QDEPTH;
         fifo_count--;
         drop_ref(old);
      end
      if (lim == 0) return;
      fifo_slot[(fifo_head + fifo_count) % QDEPTH] = s;
      fifo_count++;
      img_refs[s]++;
   endfunction

   function automatic void lookup(logic [2:0] f, logic [31:0] b);
      int s;
      s = -1;
      for (int i = 0; i < NSLOT; i++)
         if (s < 0 && img_valid[i] && img_block[i] == b) s = i;
      if (s >= 0) begin
         if (img_refs[s] >= REF_TOP) begin
            push_beat(K_ANSWER, ST_REF_OVF, s, b, 1'b1, 1'b1);
            return;
         end
         img_refs[s]++;
         if (f == F_OVERWRITE) img_dirty[s] = 1'b1;
         push_beat(K_ANSWER, ST_OK, s, b, 1'b1, 1'b1);
         return;
      end
      if (f == F_ACCESS) begin
         push_beat(K_ANSWER, ST_NOT_RES, 0, b, 1'b0, 1'b1);
         return;
      end
      for (int i = NSLOT - 1; i >= 0; i--)
         if (!img_valid[i]) s = i;
      if (s < 0) begin
         push_beat(K_ANSWER, ST_NO_SLOT, 0, b, 1'b0, 1'b1);
         return;
      end
      img_valid[s] = 1'b1;
      img_block[s] = b;
      img_refs[s] = 1;
      img_dirty[s] = 1'b0;
      if (f == F_READ) push_beat(K_FETCH, ST_OK, s, b, 1'b0, 1'b0);
      fifo_insert(s);
      if (f == F_OVERWRITE) img_dirty[s] = 1'b1;
      push_beat(K_ANSWER, ST_OK, s, b, 1'b0, 1'b1);
   endfunction

   function automatic void predict_request(logic [2:0] f, logic [31:0] b, logic [5:0] h);
      int best;
      logic [31:0] hb;
      if (f == F_READ || f == F_OVERWRITE || f == F_ACCESS) begin
         lookup(f, b);
      end else if (f == F_RELEASE || f == F_MARK) begin
         if (h >= NSLOT || !img_valid[h] || img_refs[h] == 0) begin
            push_beat(K_ANSWER, ST_BAD_HND, h, 32'd0, 1'b0, 1'b1);
         end else begin
            hb = img_block[h];
            if (f == F_MARK) img_dirty[h] = 1'b1;
            else drop_ref(h);
            push_beat(K_ANSWER, ST_OK, h, hb, 1'b0, 1'b1);
         end
      end else if (f == F_FLUSH) begin
         do begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
               if (img_valid[i] && img_dirty[i] && (best < 0 || img_block[i] < img_block[best]))
                  best = i;
            if (best >= 0) write_back(best);
         end while (best >= 0);
         push_beat(K_ANSWER, ST_OK, 0, 32'd0, 1'b0, 1'b1);
      end else begin
         push_beat(K_ANSWER, ST_OK, 0, 32'd0, 1'b0, 1'b1);
      end
   endfunction

   function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      beat_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            e = pending_beats[0];
            pending_beats.delete(0);
            check_field("kind", 48'(e.kind), 48'(rsp_tuser));
            check_field("status", 48'(e.status), 48'(rsp_tdata[2:0]));
            check_field("slot", 48'(e.slot), 48'(rsp_tdata[8:3]));
            check_field("block_id", 48'(e.block_id), 48'(rsp_tdata[40:9]));
            check_field("byte_offset", e.offset, rsp_tdata[88:41]);
            check_field("hit", 48'(e.hit), 48'(rsp_tdata[89]));
            check_field("last", 48'(e.last), 48'(rsp_tlast));
         end
      end
   end

   task automatic send_request(logic [2:0] f, logic [31:0] b, logic [5:0] h);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {2'b00, h, b};
      do @(posedge clock); while (!req_tready);
      predict_request(f, b, h);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [4:0] val);
      drain();
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CACHE_ENTRIES) entries_reg = val;
      else size_log_reg = val;
   endtask

   function automatic int pick_handle();
      int s;
      if ($urandom_range(9) == 0) return $urandom_range(63);
      for (int n = 0; n < 8; n++) begin
         s = $urandom_range(NSLOT - 1);
         if (img_valid[s] && img_refs[s] > 0) return s;
      end
      return $urandom_range(NSLOT - 1);
   endfunction

   task automatic test_directed();
      send_request(F_READ, 32'd0, 6'd0);
      send_request(F_READ, 32'd0, 6'd0);
      send_request(F_OVERWRITE, 32'hFFFF_FFFF, 6'd63);
      send_request(F_ACCESS, 32'hFFFF_FFFF, 6'd0);
      send_request(F_ACCESS, 32'h5, 6'd0);
      send_request(F_OVERWRITE, 32'hAAAA_5555, 6'h2A);
      send_request(F_MARK, 32'd0, 6'd0);
      send_request(F_RELEASE, 32'd0, 6'd63);
      send_request(F_RELEASE, 32'd0, 6'd47);
      send_request(F_MARK, 32'd0, 6'd40);
      send_request(F_FLUSH, 32'd0, 6'd0);
      send_request(3'd6, 32'h1234_5678, 6'd17);
      send_request(3'd7, 32'hFFFF_FFFF, 6'd63);
      send_request(F_RELEASE, 32'd0, 6'd1);
      send_request(F_RELEASE, 32'd0, 6'd1);
      send_request(F_RELEASE, 32'd0, 6'd1);
      send_request(F_RELEASE, 32'd0, 6'd0);
      send_request(F_ACCESS, 32'h5555_AAAA, 6'h15);
   endtask

   task automatic test_offsets();
      write_reg(CSR_SIZE_SHIFT, 5'd31);
      send_request(F_READ, 32'hFFFF_FFFF, 6'd0);
      send_request(F_FLUSH, 32'd0, 6'd0);
      write_reg(CSR_SIZE_SHIFT, 5'd0);
      send_request(F_ACCESS, 32'hFFFF_FFFF, 6'd0);
      write_reg(CSR_SIZE_SHIFT, 5'd16);
      send_request(F_ACCESS, 32'hFFFF_FFFF, 6'd0);
      send_request(F_OVERWRITE, 32'h8000_0001, 6'd0);
   endtask

   task automatic test_ref_overflow();
      for (int i = 0; i < REF_TOP + 2; i++)
         send_request(F_ACCESS, 32'h8000_0001, 6'd0);
   endtask

   task automatic test_slots_full();
      // shallow queue so every slot but the newest is held only by its handle
      write_reg(CSR_CACHE_ENTRIES, 5'd1);
      for (int i = 0; i < NSLOT + 2; i++)
         send_request((i % 2) ? F_OVERWRITE : F_READ, 32'(32'h100 + i), 6'd0);
      for (int i = 0; i < NSLOT; i++)
         if (img_valid[i] && img_refs[i] > 0 && img_refs[i] < 3)
            send_request(F_RELEASE, 32'd0, 6'(i));
      send_request(F_FLUSH, 32'd0, 6'd0);
      write_reg(CSR_CACHE_ENTRIES, 5'd16);
   endtask

   task automatic test_random(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 40)
            send_request(3'($urandom_range(2)), ($urandom_range(19) == 0) ? $urandom()
                         : blk_pool[$urandom_range(23)], 6'($urandom_range(63)));
         else if (r < 72)
            send_request(F_RELEASE, $urandom(), 6'(pick_handle()));
         else if (r < 88)
            send_request(F_MARK, $urandom(), 6'(pick_handle()));
         else if (r < 96)
            send_request(F_FLUSH, $urandom(), 6'($urandom_range(63)));
         else
            send_request(3'($urandom_range(6, 7)), $urandom(), 6'($urandom_range(63)));
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_req = 400;
      test_random(30);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      errors = 0;
      hold_req = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      entries_reg = CACHE_ENTRIES_RST;
      size_log_reg = SIZE_SHIFT_RST;
      fifo_head = 0;
      fifo_count = 0;
      for (int i = 0; i < NSLOT; i++) begin
         img_valid[i] = 1'b0; img_refs[i] = 0; img_dirty[i] = 1'b0; img_block[i] = '0;
      end
      for (int i = 0; i < 24; i++) blk_pool[i] = (i < 12) ? 32'(i) : $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_offsets();
      test_ref_overflow();
      test_slots_full();
      test_random(25);
      write_reg(CSR_CACHE_ENTRIES, 5'd3);
      write_reg(CSR_SIZE_SHIFT, 5'd0);
      send_idle_pct = 69;
      test_random(25);
      write_reg(CSR_CACHE_ENTRIES, 5'd0);
      write_reg(CSR_SIZE_SHIFT, 5'd31);
      send_idle_pct = 0;
      stall_pct = 69;
      test_random(25);
      write_reg(CSR_CACHE_ENTRIES, 5'd31);
      write_reg(CSR_SIZE_SHIFT, 5'd16);
      send_idle_pct = 25;
      stall_pct = 25;
      test_random(25);
      stall_pct = 0;
      test_backpressure();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("[block_buffer_cache_controller_top] OK");
      else
         $display("[block_buffer_cache_controller_top] ERROR");
      $finish;
   end
endmodule

FILE: files.f
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_out.sv
sv/bbc_ctrl.sv
sv/block_buffer_cache_controller_top.sv
tb/tb_top.sv
